### rtl/hapf_pkg.sv
package hapf_pkg;

   // Field widths
   localparam int VALUE_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int CHAR_W   = 8;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 4;

   // Hex characters per value, most significant nibble first (1 to 4)
   localparam int VALUE_NIBBLES = 3;
   localparam int CNT_W         = 3;
   localparam logic [CNT_W-1:0] NIB_LAST = CNT_W'(VALUE_NIBBLES - 1);
   localparam logic [CNT_W-1:0] HDR_LAST = 3'd5;
   localparam logic [CNT_W-1:0] CRC_LAST = 3'd3;

   // Characters
   localparam logic [CHAR_W-1:0] TERMINATOR = 8'h24;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] ALPHA_GAP  = 8'd7;

   // Register indexes
   localparam logic [1:0] CSR_RADAR_ID   = 2'd0;
   localparam logic [1:0] CSR_RADAR_TIME = 2'd1;
   localparam logic [1:0] CSR_CRC_POLY   = 2'd2;

   localparam logic [CRC_W-1:0] CRC_POLY_RESET = 16'hA001;

   typedef struct packed {
      logic [BYTE_W-1:0] radar_id;
      logic [BYTE_W-1:0] radar_time;
      logic [CRC_W-1:0]  crc_poly;
   } cfg_type;

   // One classified value waiting for the back end
   typedef struct packed {
      logic [VALUE_W-1:0] value_code;
      logic               header;
      logic               last;
      logic [BYTE_W-1:0]  packet_number;
   } entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HDR,
      BK_VAL,
      BK_CRC,
      BK_TERM
   } bk_state_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] a;
      a = {4'b0000, nib} + CHAR_ZERO;
      if (a > CHAR_NINE) begin
         a = a + ALPHA_GAP;
      end
      return a;
   endfunction

   // Reflected CRC-16 over one byte, eight shift steps
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, ch};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/hapf_if.sv
interface hapf_req_if;
   logic                          valid;
   logic                          ready;
   logic [hapf_pkg::VALUE_W-1:0]  value_code;
   logic                          first_value;
   logic                          last_value;
   logic [hapf_pkg::BYTE_W-1:0]   packet_number;

   modport source (output valid, value_code, first_value, last_value, packet_number,
                   input ready);
   modport sink   (input valid, value_code, first_value, last_value, packet_number,
                   output ready);
endinterface

interface hapf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hapf_pkg::CHAR_W-1:0]   ascii_char;
   logic                          run_last;
   logic                          packet_end;

   modport source (output valid, ascii_char, run_last, packet_end, input ready);
   modport sink   (input valid, ascii_char, run_last, packet_end, output ready);
endinterface

### rtl/hapf_front.sv
module hapf_front (
   input  logic                clock,
   input  logic                reset,
   hapf_req_if.sink            req,
   output logic                q_valid,
   output hapf_pkg::entry_type q_head,
   input  logic                q_pop
);

   hapf_pkg::entry_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                in_packet_ff, in_packet_in;
   logic                push;
   hapf_pkg::entry_type entry;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = mem_ff[rd_ptr_ff];

   // Classify: a header opens every packet, forced when none is open
   always_comb begin
      entry.value_code    = req.value_code;
      entry.header        = req.first_value || !in_packet_ff;
      entry.last          = req.last_value;
      entry.packet_number = req.packet_number;
   end

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      in_packet_in = in_packet_ff;
      if (push) begin
         wr_ptr_in    = !wr_ptr_ff;
         in_packet_in = !req.last_value;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
         in_packet_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         in_packet_ff <= in_packet_in;
      end
   end

   // Store the beat in the queue
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/hapf_back.sv
module hapf_back (
   input  logic                clock,
   input  logic                reset,
   input  hapf_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  hapf_pkg::entry_type q_head,
   output logic                q_pop,
   hapf_rsp_if.source          rsp
);

   hapf_pkg::bk_state_type              state_ff, state_in;
   logic [hapf_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [hapf_pkg::CRC_W-1:0]          crc_ff, crc_in;
   hapf_pkg::entry_type                 cur_ff, cur_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hapf_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                                run_last_ff, run_last_in;
   logic                                end_ff, end_in;

   logic                                can_emit;
   logic                                emit;
   logic                                done;
   logic                                feed;
   logic [hapf_pkg::CHAR_W-1:0]         ch;
   logic [hapf_pkg::BYTE_W-1:0]         hdr_byte;
   logic [15:0]                         val_pad;
   logic [1:0]                          nib_pos;
   logic [1:0]                          crc_pos;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ascii_char = char_ff;
   assign rsp.run_last   = run_last_ff;
   assign rsp.packet_end = end_ff;

   assign can_emit = !rsp_valid_ff || rsp.ready;
   assign val_pad  = {4'b0000, cur_ff.value_code};
   assign nib_pos  = 2'(hapf_pkg::NIB_LAST - cnt_ff);
   assign crc_pos  = ~cnt_ff[1:0];

   // Pick the header byte by character position
   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    hdr_byte = cfg.radar_id;
         2'd1:    hdr_byte = cfg.radar_time;
         default: hdr_byte = cur_ff.packet_number;
      endcase
   end

   // Sequence one character per cycle while the output is not held by back-pressure
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      cur_in      = cur_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      done        = 1'b0;
      feed        = 1'b0;
      ch          = hapf_pkg::TERMINATOR;
      run_last_in = 1'b0;
      end_in      = 1'b0;

      case (state_ff)
         hapf_pkg::BK_IDLE: begin
            done = 1'b1;
         end
         hapf_pkg::BK_HDR: begin
            emit = 1'b1;
            feed = 1'b1;
            ch   = hapf_pkg::hex_char(cnt_ff[0] ? hdr_byte[3:0] : hdr_byte[7:4]);
            if (can_emit) begin
               if (cnt_ff == hapf_pkg::HDR_LAST) begin
                  state_in = hapf_pkg::BK_VAL;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         hapf_pkg::BK_VAL: begin
            emit = 1'b1;
            feed = 1'b1;
            ch   = hapf_pkg::hex_char(val_pad[nib_pos*4 +: 4]);
            if (cnt_ff == hapf_pkg::NIB_LAST) begin
               if (cur_ff.last) begin
                  if (can_emit) begin
                     state_in = hapf_pkg::BK_CRC;
                     cnt_in   = '0;
                  end
               end else begin
                  run_last_in = 1'b1;
                  done        = can_emit;
               end
            end else if (can_emit) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         hapf_pkg::BK_CRC: begin
            emit = 1'b1;
            ch   = hapf_pkg::hex_char(crc_ff[crc_pos*4 +: 4]);
            if (can_emit) begin
               if (cnt_ff == hapf_pkg::CRC_LAST) begin
                  state_in = hapf_pkg::BK_TERM;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         hapf_pkg::BK_TERM: begin
            emit        = 1'b1;
            ch          = hapf_pkg::TERMINATOR;
            run_last_in = 1'b1;
            end_in      = 1'b1;
            if (can_emit) begin
               crc_in = '0;
               done   = 1'b1;
            end
         end
         default: begin
            state_in = hapf_pkg::BK_IDLE;
         end
      endcase

      // Advance the CRC over every header and value character
      if (emit && can_emit && feed) begin
         crc_in = hapf_pkg::crc_feed(crc_ff, ch, cfg.crc_poly);
      end

      // Finish the item: take the next entry or go idle
      if (done) begin
         if (q_valid) begin
            q_pop    = 1'b1;
            cur_in   = q_head;
            cnt_in   = '0;
            state_in = q_head.header ? hapf_pkg::BK_HDR : hapf_pkg::BK_VAL;
            if (q_head.header) begin
               crc_in = '0;
            end
         end else begin
            state_in = hapf_pkg::BK_IDLE;
         end
      end

      // Hold or load the output register
      char_in      = char_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit && can_emit) begin
         rsp_valid_in = 1'b1;
         char_in      = ch;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hapf_pkg::BK_IDLE;
         cnt_ff       <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit && can_emit) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         end_ff      <= end_in;
      end
   end

endmodule

### rtl/hex_ascii_packet_framer_crc16.sv
// Hex-ASCII packet framer with reflected CRC-16. Each request beat carries one
// 12-bit value; the block answers with one response beat per character, one
// character per cycle while the receiver keeps ready high, from a registered
// output. A value that opens a packet (first_value set, or no packet open) is
// preceded by six header characters (radar_id, radar_time, packet_number as
// two hex digits each); every value gives three hex digits; a value with
// last_value set adds four CRC digits and '$'. A middle value therefore gives
// 3 characters, an opening value 9, a closing value 8, and a one-value packet
// 14. A two-entry queue sits in front of the sequencer so new values are taken
// while characters are still going out. The CRC starts at 0 on each header,
// covers header and value characters, and uses crc_poly (reset 0xA001). CSRs:
// radar_id at 0x0, radar_time at 0x4, crc_poly at 0x8; write them only while
// the block is idle.
module hex_ascii_packet_framer_crc16 (
   input  logic                          clock,
   input  logic                          reset,
   hapf_req_if.sink                      req,
   hapf_rsp_if.source                    rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hapf_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hapf_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hapf_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   logic [hapf_pkg::BYTE_W-1:0] radar_id_ff;
   logic [hapf_pkg::BYTE_W-1:0] radar_time_ff;
   logic [hapf_pkg::CRC_W-1:0]  crc_poly_ff;
   logic                        csr_write;
   logic [1:0]                  csr_index;
   hapf_pkg::cfg_type           cfg;
   logic                        q_valid;
   hapf_pkg::entry_type         q_head;
   logic                        q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Write registers on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         radar_id_ff   <= '0;
         radar_time_ff <= '0;
         crc_poly_ff   <= hapf_pkg::CRC_POLY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            hapf_pkg::CSR_RADAR_ID:   radar_id_ff   <= csr_pwdata[7:0];
            hapf_pkg::CSR_RADAR_TIME: radar_time_ff <= csr_pwdata[7:0];
            hapf_pkg::CSR_CRC_POLY:   crc_poly_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         hapf_pkg::CSR_RADAR_ID:   csr_prdata = {24'h000000, radar_id_ff};
         hapf_pkg::CSR_RADAR_TIME: csr_prdata = {24'h000000, radar_time_ff};
         hapf_pkg::CSR_CRC_POLY:   csr_prdata = {16'h0000, crc_poly_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.radar_id   = radar_id_ff;
   assign cfg.radar_time = radar_time_ff;
   assign cfg.crc_poly   = crc_poly_ff;

   hapf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   hapf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

### test/hex_ascii_packet_framer_crc16_test.sv
`timescale 1ns / 100ps

module hex_ascii_packet_framer_crc16_test;

   localparam int NUM_ROWS      = 22;
   localparam int DRAIN_CYCLES  = 16;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_VALUES  = 34;

   typedef enum logic {ROW_VALUE, ROW_CSR} row_kind_type;

   // One directed step: a value beat or a register write. A nonzero text is
   // the character string the value must produce, typed in by hand.
   typedef struct packed {
      row_kind_type                 kind;
      logic [1:0]                   csr_idx;
      logic [hapf_pkg::CSR_DW-1:0]  csr_data;
      logic [hapf_pkg::VALUE_W-1:0] value_code;
      logic                         first_value;
      logic                         last_value;
      logic [hapf_pkg::BYTE_W-1:0]  packet_number;
      logic [71:0]                  text;
   } stim_row_type;

   typedef struct packed {
      logic [hapf_pkg::CHAR_W-1:0] ascii_char;
      logic                        run_last;
      logic                        packet_end;
   } char_beat_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [hapf_pkg::CSR_AW-1:0] csr_paddr;
   logic [hapf_pkg::CSR_DW-1:0] csr_pwdata;
   logic [hapf_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   hapf_req_if req_ch ();
   hapf_rsp_if rsp_ch ();

   hex_ascii_packet_framer_crc16 dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Directed steps, walked in order after reset
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'hFFF, 1'b1, 1'b0, 8'hFF, "0000FFFFF"},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h000, 1'b0, 1'b0, 8'h00, 72'("000")},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'hA5C, 1'b0, 1'b1, 8'h77, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h123, 1'b0, 1'b0, 8'h3C, "00003C123"},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h456, 1'b1, 1'b0, 8'h81, "000081456"},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h789, 1'b0, 1'b1, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_RADAR_ID, 32'h0000_00FF, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_RADAR_TIME, 32'h0000_00FF, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_CRC_POLY, 32'h0000_FFFF, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'hFFF, 1'b1, 1'b1, 8'hFF, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h000, 1'b1, 1'b1, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_CRC_POLY, 32'hFFFF_0000, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'hBCD, 1'b1, 1'b0, 8'h5A, "FFFF5ABCD"},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'hEF0, 1'b0, 1'b1, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_RADAR_ID, 32'h1234_56A5, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_RADAR_TIME, 32'hFFFF_FF5A, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_CSR, hapf_pkg::CSR_CRC_POLY, 32'h0000_A001, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h800, 1'b1, 1'b0, 8'h01, "A55A01800"},
      // change the polynomial while the packet stays open
      '{ROW_CSR, hapf_pkg::CSR_CRC_POLY, 32'h0000_8408, 12'h0, 1'b0, 1'b0, 8'h00, 72'h0},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h7FF, 1'b0, 1'b0, 8'hC3, 72'("7FF")},
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h001, 1'b0, 1'b1, 8'h00, 72'h0},
      // closing value with no packet open
      '{ROW_VALUE, hapf_pkg::CSR_RADAR_ID, 32'h0, 12'h999, 1'b0, 1'b1, 8'hE7, 72'h0}
   };

   // Shadow of the block's registers and running state
   hapf_pkg::cfg_type          cfg_shadow;
   logic [hapf_pkg::CRC_W-1:0] crc_run;
   logic                       packet_open;
   char_beat_type              frame_chars [$];
   char_beat_type              expected_chars [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned errors;
   int unsigned values_sent;
   int unsigned chars_seen;
   int unsigned packets_seen;
   int unsigned csr_writes;
   int unsigned quiet_cycles;

   always #10 clock = ~clock;

   function automatic logic [hapf_pkg::CHAR_W-1:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return {4'h3, nib};
      end
      return 8'h37 + {4'h0, nib};
   endfunction

   function automatic logic [hapf_pkg::CRC_W-1:0] crc16_shift_in(
      input logic [hapf_pkg::CRC_W-1:0]  crc,
      input logic [hapf_pkg::CHAR_W-1:0] ch,
      input logic [hapf_pkg::CRC_W-1:0]  poly);
      logic [hapf_pkg::CRC_W-1:0] c;
      c = crc ^ {8'h00, ch};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   // Append one character to the frame, folding it into the CRC if asked
   task automatic put_char(input logic [hapf_pkg::CHAR_W-1:0] ch, input logic feed,
                           input logic is_end);
      if (feed) begin
         crc_run = crc16_shift_in(crc_run, ch, cfg_shadow.crc_poly);
      end
      frame_chars.push_back('{ascii_char: ch, run_last: 1'b0, packet_end: is_end});
   endtask

   task automatic put_hex_byte(input logic [hapf_pkg::BYTE_W-1:0] b);
      put_char(nibble_ascii(b[7:4]), 1'b1, 1'b0);
      put_char(nibble_ascii(b[3:0]), 1'b1, 1'b0);
   endtask

   // Build the characters one value beat produces and advance the shadow state
   task automatic frame_value(input logic [hapf_pkg::VALUE_W-1:0] val, input logic first,
                              input logic last, input logic [hapf_pkg::BYTE_W-1:0] pnum);
      logic [15:0]                wide;
      logic [hapf_pkg::CRC_W-1:0] crc_snap;
      int                         i;
      frame_chars.delete();
      if (first || !packet_open) begin
         crc_run     = '0;
         packet_open = 1'b1;
         put_hex_byte(cfg_shadow.radar_id);
         put_hex_byte(cfg_shadow.radar_time);
         put_hex_byte(pnum);
      end
      wide = {4'h0, val};
      for (i = hapf_pkg::VALUE_NIBBLES - 1; i >= 0; i--) begin
         put_char(nibble_ascii(wide[4*i +: 4]), 1'b1, 1'b0);
      end
      if (last) begin
         crc_snap = crc_run;
         for (i = 3; i >= 0; i--) begin
            put_char(nibble_ascii(crc_snap[4*i +: 4]), 1'b0, 1'b0);
         end
         put_char(hapf_pkg::TERMINATOR, 1'b0, 1'b1);
         crc_run     = '0;
         packet_open = 1'b0;
      end
      frame_chars[frame_chars.size() - 1].run_last = 1'b1;
   endtask

   // Offer one value beat, hold it until taken, then queue its characters
   task automatic send_value(input logic [hapf_pkg::VALUE_W-1:0] val, input logic first,
                             input logic last, input logic [hapf_pkg::BYTE_W-1:0] pnum,
                             input logic [71:0] text);
      int b;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.value_code    <= val;
      req_ch.first_value   <= first;
      req_ch.last_value    <= last;
      req_ch.packet_number <= pnum;
      do @(posedge clock); while (!req_ch.ready);
      values_sent++;
      frame_value(val, first, last, pnum);
      if (text != '0) begin
         frame_chars.delete();
         for (b = 8; b >= 0; b--) begin
            if (text[8*b +: 8] != 8'h00) begin
               frame_chars.push_back('{ascii_char: text[8*b +: 8], run_last: 1'b0,
                                       packet_end: 1'b0});
            end
         end
         frame_chars[frame_chars.size() - 1].run_last = 1'b1;
      end
      foreach (frame_chars[k]) begin
         expected_chars.push_back(frame_chars[k]);
      end
   endtask

   // Drop valid and let every outstanding character come out
   task automatic drain_output();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [hapf_pkg::CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
      case (idx)
         hapf_pkg::CSR_RADAR_ID: begin
            cfg_shadow.radar_id = data[hapf_pkg::BYTE_W-1:0];
         end
         hapf_pkg::CSR_RADAR_TIME: begin
            cfg_shadow.radar_time = data[hapf_pkg::BYTE_W-1:0];
         end
         hapf_pkg::CSR_CRC_POLY: begin
            cfg_shadow.crc_poly = data[hapf_pkg::CRC_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic write_all_regs(input logic [hapf_pkg::CSR_DW-1:0] id_data,
                                 input logic [hapf_pkg::CSR_DW-1:0] time_data,
                                 input logic [hapf_pkg::CSR_DW-1:0] poly_data);
      drain_output();
      csr_write(hapf_pkg::CSR_RADAR_ID, id_data);
      csr_write(hapf_pkg::CSR_RADAR_TIME, time_data);
      csr_write(hapf_pkg::CSR_CRC_POLY, poly_data);
   endtask

   // Mostly well-formed packets of random content, with some broken framing
   task automatic run_random_packets(input int unsigned n_values);
      int unsigned sent;
      int unsigned len;
      int unsigned k;
      logic        first;
      logic        last;
      sent = 0;
      while (sent < n_values) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         for (k = 0; k < len; k++) begin
            first = (k == 0);
            last  = (k == len - 1);
            if ($urandom_range(9) == 0) begin
               first = 1'($urandom_range(1));
               last  = 1'($urandom_range(1));
            end
            send_value(12'($urandom_range(4095)), first, last, 8'($urandom_range(255)),
                       72'h0);
            sent++;
         end
      end
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each character beat with the oldest expectation
   always @(posedge clock) begin : check_rsp
      char_beat_type want;
      char_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{ascii_char: rsp_ch.ascii_char, run_last: rsp_ch.run_last,
                 packet_end: rsp_ch.packet_end};
         chars_seen++;
         if (got.packet_end) begin
            packets_seen++;
         end
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual char %h last %b end %b",
                     $time, got.ascii_char, got.run_last, got.packet_end);
         end else begin
            want = expected_chars.pop_front();
            if (want != got) begin
               errors++;
               $display("%0t: mismatch, expected %h/%b/%b, actual %h/%b/%b",
                        $time, want.ascii_char, want.run_last, want.packet_end,
                        got.ascii_char, got.run_last, got.packet_end);
            end
         end
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d characters outstanding",
                  $time, quiet_cycles, expected_chars.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.value_code    = '0;
      req_ch.first_value   = 1'b0;
      req_ch.last_value    = 1'b0;
      req_ch.packet_number = '0;
      rsp_ch.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      cfg_shadow           = '{radar_id: '0, radar_time: '0,
                               crc_poly: hapf_pkg::CRC_POLY_RESET};
      crc_run              = '0;
      packet_open          = 1'b0;
      errors               = 0;
      values_sent          = 0;
      chars_seen           = 0;
      packets_seen         = 0;
      csr_writes           = 0;
      quiet_cycles         = 0;
      send_idle_pct        = 29;
      recv_idle_pct        = 71;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed steps; register writes wait for the block to go idle
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            drain_output();
            csr_write(directed_rows[r].csr_idx, directed_rows[r].csr_data);
         end else begin
            send_value(directed_rows[r].value_code, directed_rows[r].first_value,
                       directed_rows[r].last_value, directed_rows[r].packet_number,
                       directed_rows[r].text);
         end
      end

      // Random packets under three idling patterns and register settings
      write_all_regs($urandom, $urandom, $urandom);
      run_random_packets(PHASE_VALUES);

      send_idle_pct = 71;
      recv_idle_pct = 29;
      write_all_regs(32'h0, 32'h0, $urandom);
      run_random_packets(PHASE_VALUES);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_all_regs($urandom, $urandom, {$urandom_range(65535)} | 32'h0000_8001);
      run_random_packets(PHASE_VALUES);

      drain_output();
      if (expected_chars.size() != 0) begin
         errors++;
      end

      $display("Sent %0d values over directed steps and three idling phases (%0d writes).",
               values_sent, csr_writes);
      $display("Checked %0d characters and %0d closed packets, %0d mismatches.",
               chars_seen, packets_seen, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/hapf_pkg.sv
rtl/hapf_if.sv
rtl/hapf_front.sv
rtl/hapf_back.sv
rtl/hex_ascii_packet_framer_crc16.sv
test/hex_ascii_packet_framer_crc16_test.sv
